/* hdl/b64se_pkg.sv */
// ----------------------------------------------------------------------------
// b64se_pkg
// Types, constants and the character map shared by the base64 encoder.
// ----------------------------------------------------------------------------
package b64se_pkg;

	// position of the next byte within its three-byte group
	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} phase_t;

	localparam logic [7:0] PAD_CHAR = 8'h3d;  // '='

	// one output symbol: a six-bit group or a pad
	typedef struct packed {
		logic       pad;
		logic [5:0] sextet;
	} sym_t;

	// work for one input byte: up to four symbols
	typedef struct packed {
		sym_t [3:0] syms;
		logic [1:0] last_idx;  // index of the last valid symbol
		logic       fin;
	} entry_t;

	function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
		logic [7:0] c;
		c = 8'h2f;
		case (v) inside
			[6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
			[6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
			[6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
			6'd62:         c = 8'h2b;
			default:       c = 8'h2f;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] sym_to_ascii(input sym_t s);
		return s.pad ? PAD_CHAR : sextet_to_ascii(s.sextet);
	endfunction

endpackage

/* hdl/b64se_front.sv */
// ----------------------------------------------------------------------------
// b64se_front
// Accepts raw bytes, tracks the group phase and leftover bits, and turns each
// byte into the list of symbols it produces.
// ----------------------------------------------------------------------------
module b64se_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	input  logic              q_full,
	output logic              push,
	output b64se_pkg::entry_t push_entry
);
	import b64se_pkg::*;

	phase_t     phase_q, phase_d;
	logic [3:0] carry_q, carry_d;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// next state
	always_comb begin
		phase_d = phase_q;
		carry_d = carry_q;
		if (push) begin
			case (phase_q)
				PH_SECOND: begin
					phase_d = PH_THIRD;
					carry_d = data_byte[3:0];
				end
				PH_THIRD: begin
					phase_d = PH_FIRST;
					carry_d = 4'd0;
				end
				default: begin
					phase_d = PH_SECOND;
					carry_d = {2'b00, data_byte[1:0]};
				end
			endcase
			if (final_byte) begin
				phase_d = PH_FIRST;
				carry_d = 4'd0;
			end
		end
	end

	// symbols for the current byte
	always_comb begin
		push_entry          = '0;
		push_entry.fin      = final_byte;
		case (phase_q)
			PH_SECOND: begin
				push_entry.syms[0].sextet = {carry_q[1:0], data_byte[7:4]};
				if (final_byte) begin
					push_entry.syms[1].sextet = {data_byte[3:0], 2'b00};
					push_entry.syms[2].pad    = 1'b1;
					push_entry.last_idx       = 2'd2;
				end
			end
			PH_THIRD: begin
				push_entry.syms[0].sextet = {carry_q, data_byte[7:6]};
				push_entry.syms[1].sextet = data_byte[5:0];
				push_entry.last_idx       = 2'd1;
			end
			default: begin
				push_entry.syms[0].sextet = data_byte[7:2];
				if (final_byte) begin
					push_entry.syms[1].sextet = {data_byte[1:0], 4'b0000};
					push_entry.syms[2].pad    = 1'b1;
					push_entry.syms[3].pad    = 1'b1;
					push_entry.last_idx       = 2'd3;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			carry_q <= 4'd0;
		end else begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

endmodule

/* hdl/b64se_queue.sv */
// ----------------------------------------------------------------------------
// b64se_queue
// Small register queue of per-byte work between front and back.
// ----------------------------------------------------------------------------
module b64se_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64se_pkg::entry_t push_entry,
	output logic              full,
	input  logic              pop,
	output logic              q_valid,
	output b64se_pkg::entry_t head_entry
);
	import b64se_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == FULL_CNT);
	assign q_valid    = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/b64se_back.sv */
// ----------------------------------------------------------------------------
// b64se_back
// Steps through the symbols of each queued byte and drives the registered
// output, one character per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module b64se_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  b64se_pkg::entry_t head_entry,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_char,
	output logic              run_end,
	output logic              text_end
);
	import b64se_pkg::*;

	entry_t     cur_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] char_q;
	logic       run_end_q, text_end_q;

	logic adv, emit, last;

	assign adv  = !out_valid_q || !out_stall;
	assign emit = busy_q && adv;
	assign last = (idx_q == cur_q.last_idx);
	// fetch the next word as the current one hands over its last symbol
	assign pop  = q_valid && (!busy_q || (emit && last));

	assign out_valid = out_valid_q;
	assign out_char  = char_q;
	assign run_end   = run_end_q;
	assign text_end  = text_end_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_entry;
		end
		if (emit) begin
			char_q     <= sym_to_ascii(cur_q.syms[idx_q]);
			run_end_q  <= last;
			text_end_q <= last && cur_q.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (emit) begin
				busy_q <= !last;
				idx_q  <= idx_q + 2'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (adv) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hdl/base64_stream_encoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder (standard alphabet, '=' padded).
// ----------------------------------------------------------------------------
// One raw byte goes in per word; base64 characters come out one per cycle
// while out_stall is low. The front takes a byte every cycle while its queue
// has room and turns it into one to four symbols; the back drains the queue at
// one character per cycle while out_stall is low, so the output port sets the
// rate: a byte yields one character in group positions one and two, two in
// position three, and up to four when it is marked final. A byte is registered
// in the queue, then in the back's current entry, then as a character in the
// output register. QUEUE_DEPTH sets how many bytes the front may run ahead of
// the output. run_end flags the last character of each byte and text_end the
// last character of a final byte.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       run_end,
	output logic       text_end
);
	import b64se_pkg::*;

	logic   q_full, push, pop, q_valid;
	entry_t push_entry, head_entry;

	b64se_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	b64se_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.q_valid    (q_valid),
		.head_entry (head_entry)
	);

	b64se_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.run_end    (run_end),
		.text_end   (text_end)
	);

endmodule

/* test/b64_text_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b64_text_check
// Watches both channels of the encoder and encodes every byte it accepts. It
// compares each character that leaves the block with the oldest character
// still owed, field by field.
// ----------------------------------------------------------------------------
module b64_text_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] out_char,
	input  logic       run_end,
	input  logic       text_end,
	output int         errors,
	output int         pending
);
	import b64se_pkg::*;

	localparam logic [0:64*8-1] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [7:0] ch;
		logic       run_end;
		logic       text_end;
	} b64_char_t;

	b64_char_t  owed_chars[$];
	b64_char_t  got;
	b64_char_t  want;
	phase_t     grp_phase = PH_FIRST;
	logic [3:0] left_bits = '0;
	int         n_err = 0;
	int         n_owed = 0;

	assign errors  = n_err;
	assign pending = n_owed;

	function automatic logic [7:0] b64_digit(input logic [5:0] v);
		return ALPHABET[int'(v) * 8 +: 8];
	endfunction

	task automatic report(input string msg);
		$display("%0t ns  mismatch: %s", $time, msg);
		n_err = n_err + 1;
	endtask

	// appends the characters that one byte completes
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		logic [7:0] chars[4];
		int n;
		b64_char_t c;
		case (grp_phase)
			PH_SECOND: begin
				chars[0] = b64_digit({left_bits[1:0], b[7:4]});
				left_bits = b[3:0];
				grp_phase = PH_THIRD;
				n = 1;
				if (fin) begin
					chars[1] = b64_digit({b[3:0], 2'b00});
					chars[2] = PAD_CHAR;
					n = 3;
				end
			end
			PH_THIRD: begin
				chars[0] = b64_digit({left_bits, b[7:6]});
				chars[1] = b64_digit(b[5:0]);
				left_bits = '0;
				grp_phase = PH_FIRST;
				n = 2;
			end
			default: begin
				chars[0] = b64_digit(b[7:2]);
				left_bits = {2'b00, b[1:0]};
				grp_phase = PH_SECOND;
				n = 1;
				if (fin) begin
					chars[1] = b64_digit({b[1:0], 4'b0000});
					chars[2] = PAD_CHAR;
					chars[3] = PAD_CHAR;
					n = 4;
				end
			end
		endcase
		if (fin) begin
			grp_phase = PH_FIRST;
			left_bits = '0;
		end
		for (int k = 0; k < n; k++) begin
			c.ch       = chars[k];
			c.run_end  = (k == n - 1);
			c.text_end = (k == n - 1) && fin;
			owed_chars = {owed_chars, c};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_phase = PH_FIRST;
			left_bits = '0;
		end else begin
			if (in_valid && !in_stall)
				encode_byte(data_byte, final_byte);
			if (out_valid && !out_stall) begin
				got = '{out_char, run_end, text_end};
				if (owed_chars.size() == 0) begin
					report($sformatf("char %h run_end %b text_end %b with nothing owed",
						out_char, run_end, text_end));
				end else begin
					want = owed_chars.pop_front();
					if (got.ch !== want.ch)
						report($sformatf("out_char %h, want %h", got.ch, want.ch));
					if (got.run_end !== want.run_end)
						report($sformatf("run_end %b, want %b (char %h)",
							got.run_end, want.run_end, want.ch));
					if (got.text_end !== want.text_end)
						report($sformatf("text_end %b, want %b (char %h)",
							got.text_end, want.text_end, want.ch));
				end
			end
			// nonblocking so the stimulus side sees a settled count
			n_owed <= owed_chars.size();
		end
	end

endmodule

/* test/base64_stream_encoder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_test
// Feeds the encoder directed buffers (pads after each group position, all-ones
// and all-zeros bytes, the '+' and '/' digits), then random buffers under four
// mixes of sender gaps and receiver stalls. b64_text_check does the checking.
// ----------------------------------------------------------------------------
module base64_stream_encoder_test;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       final_byte;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic       run_end;
	logic       text_end;
	int         errors;
	int         pending;
	int         idle_pct = 0;
	int         stall_pct = 0;
	int         sent = 0;

	base64_stream_encoder DUT (.*);

	b64_text_check text_check (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		final_byte <= fin;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// hold the sender off until every owed character is out
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int goal;
		int len;
		logic open_run;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		data_byte  <= '0;
		final_byte <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pads after a lone byte, after two, and none after three
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h4d, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6e, 1'b1);
		// "++++////"
		send_byte(8'hfb, 1'b0);
		send_byte(8'hef, 1'b0);
		send_byte(8'hbe, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h83, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h51, 1'b0);
		send_byte(8'h87, 1'b1);
		send_byte(8'h01, 1'b1);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 56; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 56; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			goal = sent + 50;
			while (sent < goal) begin
				len = $urandom_range(1, 9);
				// now and then a run with no final byte, so the next buffer
				// starts mid-group
				open_run = ($urandom_range(9) == 0);
				for (int k = 0; k < len; k++)
					send_byte(8'($urandom_range(255)), !open_run && (k == len - 1));
				if ($urandom_range(7) == 0)
					drain();
			end
			drain();
		end

		stall_pct = 0;
		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("base64_stream_encoder_test: done, clean");
		else
			$display("base64_stream_encoder_test: done, errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("base64_stream_encoder_test: done, errors");
		$finish;
	end

endmodule
